>>> hdl/block_reassembly_tracker_defines.svh
// Assertion helpers used by block_reassembly_tracker.
`ifndef BLOCK_REASSEMBLY_TRACKER_DEFINES_SVH
`define BLOCK_REASSEMBLY_TRACKER_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define BRT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define BRT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/brt_pkg.sv
package brt_pkg;

    localparam int FIELD_W         = 25;
    localparam int REQ_W           = 2;
    localparam int STATUS_W        = 2;
    localparam int CFG_IDX_W       = 1;
    localparam int TABLE_DEPTH_DEF = 16;
    localparam int OFFSET_BITS_DEF = 25;

    localparam logic [FIELD_W-1:0] PIECE_SIZE_RST = 25'd262144;
    localparam logic [FIELD_W-1:0] MAX_REQ_RST    = 25'd16384;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PLAN   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_HASH   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUPL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERRUN = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_PIECE_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_REQ    = 1'd1;

endpackage

>>> hdl/brt_ram.sv
module brt_ram #(
    parameter int WIDTH = 50,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/block_reassembly_tracker.sv
// Channel | Direction | Handshake            | Word
// input   | in        | in_valid / in_stall  | req_type, position, block_length, hash_ok
// output  | out       | out_valid / out_stall| status, prefix_size, piece_complete,
//         |           |                      | bytes_credited, request_size, request_end
// config  | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One word is worked on at a time; in_stall is high from acceptance until the result is
// loaded into the output register. The out-of-order table sits in one RAM with a
// registered read, and each sweep reads every entry of it once.
// An insert not already covered by the prefix takes one duplicate sweep plus one sweep
// per absorbing pass; a plan takes one or more sweeps likewise, and a hash verdict takes
// no sweep. Reset clears the prefix, the valid bits and the control registers; the RAM
// itself is not cleared. A stalled result holds while the next word waits.
module block_reassembly_tracker #(
    parameter int TABLE_DEPTH = brt_pkg::TABLE_DEPTH_DEF,
    parameter int OFFSET_BITS = brt_pkg::OFFSET_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [brt_pkg::REQ_W-1:0]       req_type,
    input  logic [brt_pkg::FIELD_W-1:0]     position,
    input  logic [brt_pkg::FIELD_W-1:0]     block_length,
    input  logic                            hash_ok,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [brt_pkg::STATUS_W-1:0]    status,
    output logic [brt_pkg::FIELD_W-1:0]     prefix_size,
    output logic                            piece_complete,
    output logic [brt_pkg::FIELD_W-1:0]     bytes_credited,
    output logic [brt_pkg::FIELD_W-1:0]     request_size,
    output logic [brt_pkg::FIELD_W-1:0]     request_end,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [brt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [brt_pkg::FIELD_W-1:0]     cfg_data
);

    import brt_pkg::*;

`include "block_reassembly_tracker_defines.svh"

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int XW = ((OFFSET_BITS > FIELD_W) ? OFFSET_BITS : FIELD_W) + 1;
    localparam int OB = OFFSET_BITS;
    localparam logic [XW-1:0] OFS_MAX  = (XW'(1) << OFFSET_BITS) - XW'(1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(TABLE_DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_DUP, S_ABSORB, S_PMIN, S_PEXT, S_FINISH
    } state_t;

    // Saturate an offset at the largest value the offset width holds.
    function automatic logic [XW-1:0] sat(input logic [XW-1:0] v);
        return (v > OFS_MAX) ? OFS_MAX : v;
    endfunction

    state_t               state_reg;
    logic [REQ_W-1:0]     type_reg;
    logic [OB-1:0]        pos_reg;
    logic [OB-1:0]        len_reg;
    logic [OB-1:0]        prefix_reg;
    logic [OB-1:0]        orig_reg;
    logic [OB-1:0]        small_reg;
    logic [OB-1:0]        rend_reg;
    logic [FIELD_W-1:0]   rsize_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic                 credit_en_reg;
    logic                 found_reg;
    logic                 hit_reg;
    logic [CW-1:0]        cnt_reg;
    logic [IW-1:0]        chk_idx_reg;
    logic                 chk_vld_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [FIELD_W-1:0]   piece_reg;
    logic [FIELD_W-1:0]   maxreq_reg;
    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  status_out_reg;
    logic [FIELD_W-1:0]   prefix_out_reg;
    logic                 complete_out_reg;
    logic [FIELD_W-1:0]   credit_out_reg;
    logic [FIELD_W-1:0]   rsize_out_reg;
    logic [FIELD_W-1:0]   rend_out_reg;

    // Table RAM: start offset in the upper half, size in the lower half.
    logic                 ram_we;
    logic [IW-1:0]        free_idx;
    logic                 free_any;
    logic [2*OB-1:0]      rd_data;

    brt_ram #(
        .WIDTH (2 * OB),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (free_idx),
        .wdata ({pos_reg, len_reg}),
        .raddr (cnt_reg[IW-1:0]),
        .rdata (rd_data)
    );

    // Lowest free entry of the table.
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    logic [XW-1:0] pos_in_x, len_in_x, in_end_x, pref_x, piece_x, max_x;
    logic [XW-1:0] base_x, rsize0_x, pos_x, len_x, rend_x;
    logic [XW-1:0] s_x, e_x, abs_new_x, diff_x, rs_x, rend_c_x, ins_end_x;
    logic [OB-1:0] ent_start, ent_size, small_fin;
    logic          ent_live, sweep_end, issue, sweep_restart;
    logic          dup_hit, abs_hit, min_hit, ext_hit, found_fin;
    logic [STATUS_W-1:0] status_fin;

    assign pos_in_x  = XW'(position) & OFS_MAX;
    assign len_in_x  = XW'(block_length) & OFS_MAX;
    assign in_end_x  = pos_in_x + len_in_x;
    assign pref_x    = XW'(prefix_reg);
    assign piece_x   = XW'(piece_reg);
    assign max_x     = XW'(maxreq_reg);
    assign base_x    = (piece_x > pos_in_x) ? (piece_x - pos_in_x) : '0;
    assign rsize0_x  = (base_x > max_x) ? max_x : base_x;
    assign pos_x     = XW'(pos_reg);
    assign len_x     = XW'(len_reg);
    assign rend_x    = XW'(rend_reg);
    assign ins_end_x = sat(pos_x + len_x);

    assign ent_start = rd_data[2*OB-1:OB];
    assign ent_size  = rd_data[OB-1:0];
    assign s_x       = XW'(ent_start);
    assign e_x       = sat(s_x + XW'(ent_size));
    assign ent_live  = chk_vld_reg && valid_reg[chk_idx_reg];
    assign sweep_end = chk_vld_reg && (chk_idx_reg == LAST_IDX);
    assign issue     = (cnt_reg < DEPTH_C);

    assign dup_hit   = ent_live && (ent_start == pos_reg) && (ent_size == len_reg);
    assign abs_hit   = ent_live && (s_x <= pref_x);
    assign abs_new_x = (e_x > pref_x) ? e_x : pref_x;
    assign min_hit   = ent_live && (s_x > pos_x) && (!found_reg || (ent_start < small_reg));
    assign ext_hit   = ent_live && (s_x <= rend_x) && (e_x > rend_x);
    assign small_fin = min_hit ? ent_start : small_reg;
    assign found_fin = found_reg || min_hit;
    assign diff_x    = XW'(small_fin) - pos_x;
    assign rs_x      = (diff_x > max_x) ? max_x : diff_x;
    assign rend_c_x  = sat(pos_x + rs_x);

    // A sweep that ends and is followed straight away by another one.
    assign sweep_restart = sweep_end && (
        ((state_reg == S_DUP) && !(found_reg || dup_hit) && (pos_x <= pref_x)) ||
        ((state_reg == S_ABSORB) && (hit_reg || abs_hit)) ||
        ((state_reg == S_PMIN) && found_fin) ||
        ((state_reg == S_PEXT) && (hit_reg || ext_hit)));

    assign ram_we = (state_reg == S_DUP) && sweep_end && !(found_reg || dup_hit)
                    && (pos_x > pref_x) && free_any;

    // An item that still reports ok after an insert is flagged when it ran past the piece.
    assign status_fin = ((type_reg == REQ_INSERT) && (status_reg == ST_OK)
                         && (pref_x > piece_x)) ? ST_OVERRUN : status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            prefix_reg    <= '0;
            valid_reg     <= '0;
            piece_reg     <= PIECE_SIZE_RST;
            maxreq_reg    <= MAX_REQ_RST;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            chk_vld_reg   <= 1'b0;
            chk_idx_reg   <= '0;
            found_reg     <= 1'b0;
            hit_reg       <= 1'b0;
            credit_en_reg <= 1'b0;
            status_reg    <= ST_OK;
            type_reg      <= REQ_INSERT;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_PIECE_SIZE: piece_reg  <= cfg_data;
                    CFG_MAX_REQ:    maxreq_reg <= cfg_data;
                endcase
            end

            // A result taken while a new one is being loaded is replaced in S_FINISH.
            if (out_valid_reg && !out_stall && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            // Sweep engine: one read issued per cycle, its data checked once the registered read returns.
            if (state_reg == S_DUP || state_reg == S_ABSORB ||
                state_reg == S_PMIN || state_reg == S_PEXT)
            begin
                if (sweep_restart)
                begin
                    cnt_reg     <= '0;
                    chk_vld_reg <= 1'b0;
                end
                else
                begin
                    if (issue)
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                    chk_vld_reg <= issue;
                end
                chk_idx_reg <= cnt_reg[IW-1:0];
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        type_reg      <= req_type;
                        pos_reg       <= OB'(pos_in_x);
                        len_reg       <= OB'(len_in_x);
                        orig_reg      <= prefix_reg;
                        status_reg    <= ST_OK;
                        credit_en_reg <= 1'b0;
                        rsize_reg     <= '0;
                        rend_reg      <= '0;
                        found_reg     <= 1'b0;
                        hit_reg       <= 1'b0;
                        cnt_reg       <= '0;
                        chk_vld_reg   <= 1'b0;
                        unique case (req_type)
                            REQ_INSERT:
                            begin
                                if (in_end_x <= pref_x)
                                begin
                                    status_reg <= ST_DUPL;
                                    state_reg  <= S_FINISH;
                                end
                                else
                                begin
                                    state_reg <= S_DUP;
                                end
                            end
                            REQ_PLAN:
                            begin
                                rsize_reg <= FIELD_W'(rsize0_x);
                                rend_reg  <= OB'(sat(pos_in_x + rsize0_x));
                                state_reg <= S_PMIN;
                            end
                            REQ_HASH:
                            begin
                                if (!hash_ok)
                                begin
                                    prefix_reg <= '0;
                                end
                                state_reg <= S_FINISH;
                            end
                            default:
                            begin
                                state_reg <= S_FINISH;
                            end
                        endcase
                    end
                end

                S_DUP:
                begin
                    if (dup_hit)
                    begin
                        found_reg <= 1'b1;
                    end
                    if (sweep_end)
                    begin
                        if (found_reg || dup_hit)
                        begin
                            status_reg <= ST_DUPL;
                            state_reg  <= S_FINISH;
                        end
                        else if (pos_x <= pref_x)
                        begin
                            if (ins_end_x > pref_x)
                            begin
                                prefix_reg <= OB'(ins_end_x);
                            end
                            credit_en_reg <= 1'b1;
                            hit_reg       <= 1'b0;
                            state_reg     <= S_ABSORB;
                        end
                        else if (free_any)
                        begin
                            valid_reg[free_idx] <= 1'b1;
                            state_reg           <= S_FINISH;
                        end
                        else
                        begin
                            status_reg <= ST_FULL;
                            state_reg  <= S_FINISH;
                        end
                    end
                end

                S_ABSORB:
                begin
                    if (abs_hit)
                    begin
                        prefix_reg             <= OB'(abs_new_x);
                        valid_reg[chk_idx_reg] <= 1'b0;
                    end
                    hit_reg <= !sweep_end && (hit_reg || abs_hit);
                    if (sweep_end && !(hit_reg || abs_hit))
                    begin
                        state_reg <= S_FINISH;
                    end
                end

                S_PMIN:
                begin
                    if (min_hit)
                    begin
                        small_reg <= ent_start;
                        found_reg <= 1'b1;
                    end
                    if (sweep_end)
                    begin
                        if (found_fin)
                        begin
                            rsize_reg   <= FIELD_W'(rs_x);
                            rend_reg    <= OB'(rend_c_x);
                            hit_reg     <= 1'b0;
                            state_reg   <= S_PEXT;
                        end
                        else
                        begin
                            state_reg <= S_FINISH;
                        end
                    end
                end

                S_PEXT:
                begin
                    if (ext_hit)
                    begin
                        rend_reg <= OB'(e_x);
                    end
                    hit_reg <= !sweep_end && (hit_reg || ext_hit);
                    if (sweep_end && !(hit_reg || ext_hit))
                    begin
                        state_reg <= S_FINISH;
                    end
                end

                S_FINISH:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg    <= 1'b1;
                        status_out_reg   <= status_fin;
                        prefix_out_reg   <= FIELD_W'(prefix_reg);
                        complete_out_reg <= (pref_x == piece_x);
                        credit_out_reg   <= credit_en_reg ? FIELD_W'(prefix_reg - orig_reg)
                                                          : '0;
                        rsize_out_reg    <= rsize_reg;
                        rend_out_reg     <= FIELD_W'(rend_reg);
                        state_reg        <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign cfg_ready      = 1'b1;
    assign out_valid      = out_valid_reg;
    assign status         = status_out_reg;
    assign prefix_size    = prefix_out_reg;
    assign piece_complete = complete_out_reg;
    assign bytes_credited = credit_out_reg;
    assign request_size   = rsize_out_reg;
    assign request_end    = rend_out_reg;

    // The prefix only moves backwards on a hash failure, which is taken while idle.
    `BRT_ASSERT_NEXT(a_prefix_monotone, state_reg != S_IDLE, prefix_reg >= $past(prefix_reg))
    // A stored block always lands in an entry that then reads as occupied.
    `BRT_ASSERT_NEXT(a_store_marks_valid, ram_we, valid_reg[$past(free_idx)])
    // At most one entry is taken per cycle.
    `BRT_ASSERT_NEXT(a_one_store, 1'b1,
        $countones(valid_reg) <= $past($countones(valid_reg)) + 1)

endmodule
